>>> hw/rtl/stbs_pkg.sv
// Shared widths, types and codes for the sorted table binary search block.
`default_nettype none

package stbs_pkg;

   localparam int TABLE_DEPTH  = 256;
   localparam int KEY_WIDTH    = 8;
   localparam int INDEX_WIDTH  = $clog2(TABLE_DEPTH);
   localparam int COUNT_WIDTH  = INDEX_WIDTH + 1;

   // The queue depth must be a power of two so the pointers wrap naturally.
   localparam int QUEUE_DEPTH  = 2;
   localparam int QPTR_WIDTH   = $clog2(QUEUE_DEPTH);
   localparam int QCOUNT_WIDTH = QPTR_WIDTH + 1;

   localparam logic REQ_WRITE  = 1'b0;
   localparam logic REQ_SEARCH = 1'b1;

   typedef logic [INDEX_WIDTH-1:0] index_type;
   typedef logic [KEY_WIDTH-1:0]   key_type;
   typedef logic [COUNT_WIDTH-1:0] count_type;

   typedef enum logic [1:0] {
      OP_WRITE,
      OP_SEARCH,
      OP_REJECT
   } op_kind_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_RESP
   } state_type;

   typedef struct packed {
      op_kind_type kind;
      index_type   entry_index;
      key_type     key_value;
      index_type   lo_index;
      index_type   hi_index;
   } op_type;

endpackage

`default_nettype wire

>>> hw/rtl/stbs_req_if.sv
// Request channel: table writes and search requests.
`default_nettype none

interface stbs_req_if;
   logic                          valid;
   logic                          ready;
   logic                          req_type;
   logic [stbs_pkg::INDEX_WIDTH-1:0] entry_index;
   logic [stbs_pkg::KEY_WIDTH-1:0]   key_value;
   logic [stbs_pkg::INDEX_WIDTH-1:0] low_bound;
   logic [stbs_pkg::INDEX_WIDTH-1:0] high_bound;

   modport source (
      output valid, req_type, entry_index, key_value, low_bound, high_bound,
      input  ready
   );

   modport sink (
      input  valid, req_type, entry_index, key_value, low_bound, high_bound,
      output ready
   );
endinterface

`default_nettype wire

>>> hw/rtl/stbs_rsp_if.sv
// Response channel: search results.
`default_nettype none

interface stbs_rsp_if;
   logic                             valid;
   logic                             ready;
   logic                             found;
   logic [stbs_pkg::INDEX_WIDTH-1:0] found_index;

   modport source (
      output valid, found, found_index,
      input  ready
   );

   modport sink (
      input  valid, found, found_index,
      output ready
   );
endinterface

`default_nettype wire

>>> hw/rtl/stbs_front.sv
// Front end: holds the entry count register, accepts requests and classifies them.
`default_nettype none

module stbs_front (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_write_en,
   input  wire logic [stbs_pkg::COUNT_WIDTH-1:0] csr_write_data,
   stbs_req_if.sink                           req,
   output stbs_pkg::op_type                   push_op,
   output logic                               push_valid,
   input  wire logic                          push_ready
);
   import stbs_pkg::*;

   count_type entry_count_ff;
   count_type eff_count;
   count_type hi_ext;
   count_type lo_ext;
   logic      reject;

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_count_ff <= '0;
      end else if (csr_write_en) begin
         entry_count_ff <= csr_write_data;
      end
   end

   // The count saturates at the table depth. An empty table is covered by the
   // upper bound check, since any high bound is at or beyond a count of zero.
   always_comb begin
      eff_count = (entry_count_ff > COUNT_WIDTH'(TABLE_DEPTH)) ?
                  COUNT_WIDTH'(TABLE_DEPTH) : entry_count_ff;
      hi_ext    = {1'b0, req.high_bound};
      lo_ext    = {1'b0, req.low_bound};
      reject    = (lo_ext > hi_ext) || (hi_ext >= eff_count);
   end

   always_comb begin
      push_op.entry_index = req.entry_index;
      push_op.key_value   = req.key_value;
      push_op.lo_index    = req.low_bound;
      push_op.hi_index    = req.high_bound;
      if (req.req_type == REQ_WRITE) begin
         push_op.kind = OP_WRITE;
      end else if (reject) begin
         push_op.kind = OP_REJECT;
      end else begin
         push_op.kind = OP_SEARCH;
      end
   end

   assign push_valid = req.valid;
   assign req.ready  = push_ready;

endmodule

`default_nettype wire

>>> hw/rtl/stbs_queue.sv
// Short queue of classified operations between the front and back ends.
`default_nettype none

module stbs_queue (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire stbs_pkg::op_type push_op,
   input  wire logic     push_valid,
   output logic          push_ready,
   output stbs_pkg::op_type pop_op,
   output logic          pop_valid,
   input  wire logic     pop_ready
);
   import stbs_pkg::*;

   op_type                  slot_ff [QUEUE_DEPTH];
   logic [QPTR_WIDTH-1:0]   wr_ptr_ff;
   logic [QPTR_WIDTH-1:0]   rd_ptr_ff;
   logic [QCOUNT_WIDTH-1:0] count_ff;
   logic [QCOUNT_WIDTH-1:0] count_in;
   logic                    push;
   logic                    pop;

   assign push_ready = (count_ff != QCOUNT_WIDTH'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_op     = slot_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_op;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCOUNT_WIDTH'(QUEUE_DEPTH))
      else $error("queue count exceeds its depth");

   a_count_grow: assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> count_ff == $past(count_ff) + 1'b1)
      else $error("queue count did not follow a lone push");

endmodule

`default_nettype wire

>>> hw/rtl/stbs_back.sv
// Back end: key table memory, halving search engine and result register.
`default_nettype none

module stbs_back (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire stbs_pkg::op_type pop_op,
   input  wire logic        pop_valid,
   output logic             pop_ready,
   stbs_rsp_if.source       rsp
);
   import stbs_pkg::*;

   state_type state_ff;
   state_type state_in;

   key_type   key_table_mem [TABLE_DEPTH];
   key_type   rd_data_ff;
   index_type rd_addr;
   logic      mem_we;

   count_type lo_ff;
   count_type lo_in;
   count_type hi_ff;
   count_type hi_in;
   index_type mid_ff;
   index_type mid_in;
   key_type   key_ff;
   key_type   key_in;
   logic      found_ff;
   logic      found_in;
   index_type found_index_ff;
   index_type found_index_in;

   count_type head_mid;
   count_type mid_ext;
   count_type next_lo;
   count_type next_hi;
   count_type next_mid;
   logic      hit;
   logic      range_empty;

   function automatic count_type mid_of(input count_type lo, input count_type hi);
      count_type span;
      span = hi - lo;
      return lo + (span >> 1);
   endfunction

   // One probe per cycle: compare the entry read last cycle, narrow the
   // range, and issue the read of the next midpoint.
   always_comb begin
      head_mid = mid_of({1'b0, pop_op.lo_index}, {1'b0, pop_op.hi_index});
      mid_ext  = {1'b0, mid_ff};
      hit      = (rd_data_ff == key_ff);
      if (key_ff < rd_data_ff) begin
         next_lo     = lo_ff;
         next_hi     = mid_ext - 1'b1;
         range_empty = (mid_ff == '0) || (lo_ff > next_hi);
      end else begin
         next_lo     = mid_ext + 1'b1;
         next_hi     = hi_ff;
         range_empty = (next_lo > hi_ff);
      end
      next_mid = mid_of(next_lo, next_hi);
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (pop_valid) begin
               case (pop_op.kind)
                  OP_SEARCH: state_in = ST_SEARCH;
                  OP_REJECT: state_in = ST_RESP;
                  default:   state_in = ST_IDLE;
               endcase
            end
         end
         ST_SEARCH: begin
            if (hit || range_empty) begin
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            if (rsp.ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      pop_ready      = 1'b0;
      mem_we         = 1'b0;
      rd_addr        = next_mid[INDEX_WIDTH-1:0];
      lo_in          = lo_ff;
      hi_in          = hi_ff;
      mid_in         = mid_ff;
      key_in         = key_ff;
      found_in       = found_ff;
      found_index_in = found_index_ff;
      case (state_ff)
         ST_IDLE: begin
            pop_ready = 1'b1;
            rd_addr   = head_mid[INDEX_WIDTH-1:0];
            if (pop_valid) begin
               mem_we         = (pop_op.kind == OP_WRITE);
               lo_in          = {1'b0, pop_op.lo_index};
               hi_in          = {1'b0, pop_op.hi_index};
               mid_in         = head_mid[INDEX_WIDTH-1:0];
               key_in         = pop_op.key_value;
               found_in       = 1'b0;
               found_index_in = '0;
            end
         end
         ST_SEARCH: begin
            if (hit) begin
               found_in       = 1'b1;
               found_index_in = mid_ff;
            end else if (range_empty) begin
               found_in       = 1'b0;
               found_index_in = '0;
            end else begin
               lo_in  = next_lo;
               hi_in  = next_hi;
               mid_in = next_mid[INDEX_WIDTH-1:0];
            end
         end
         ST_RESP: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff          <= lo_in;
      hi_ff          <= hi_in;
      mid_ff         <= mid_in;
      key_ff         <= key_in;
      found_ff       <= found_in;
      found_index_ff <= found_index_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         key_table_mem[pop_op.entry_index] <= pop_op.key_value;
      end
      rd_data_ff <= key_table_mem[rd_addr];
   end

   assign rsp.valid       = (state_ff == ST_RESP);
   assign rsp.found       = found_ff;
   assign rsp.found_index = found_index_ff;

   a_range_order: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SEARCH |-> lo_ff <= hi_ff)
      else $error("search range is empty while searching");

   a_mid_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SEARCH |-> ({1'b0, mid_ff} >= lo_ff) && ({1'b0, mid_ff} <= hi_ff))
      else $error("probe index lies outside the search range");

   a_miss_index: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.found |-> rsp.found_index == '0)
      else $error("not found result carries a nonzero index");

endmodule

`default_nettype wire

>>> hw/rtl/sorted_table_binary_search.sv
// Top level of the sorted table binary search block.
`default_nettype none

// Channel   Role    Handshake      Payload
// req_chan  input   valid/ready    req_type, entry_index, key_value, low_bound, high_bound
// rsp_chan  output  valid/ready    found, found_index
// csr_*     config  write enable   csr_write_data (entry count, 9 bits)
//
// A write item updates the key table as it leaves the queue. A search item
// first issues the read of its first midpoint, then probes the key table one
// entry per probe through the single read port (at most nine probes for a
// full table of 256 entries) and waits in the result register until taken.
// A search rejected by its bounds goes straight to the result register.
// Reset clears the entry count, the queue and the search state; the key table
// is not cleared and holds nothing meaningful until written.
// The two-entry queue lets the front end keep accepting items while the back
// end searches or holds a result that the consumer has not taken yet.

module sorted_table_binary_search (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_write_en,
   input  wire logic [stbs_pkg::COUNT_WIDTH-1:0] csr_write_data,
   stbs_req_if.sink                              req_chan,
   stbs_rsp_if.source                            rsp_chan
);
   import stbs_pkg::*;

   // Classified operations flowing from the front end into the queue.
   op_type push_op;
   logic   push_valid;
   logic   push_ready;

   // Queue head as seen by the back end.
   op_type pop_op;
   logic   pop_valid;
   logic   pop_ready;

   // The front end checks search bounds against the entry count as each item
   // arrives, so the back end only ever runs searches over a valid range.
   stbs_front u_front (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .req            (req_chan),
      .push_op        (push_op),
      .push_valid     (push_valid),
      .push_ready     (push_ready)
   );

   // Writes travel through the queue as well, so table updates and searches
   // keep the order in which the items were accepted.
   stbs_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_op    (push_op),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .pop_op     (pop_op),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready)
   );

   // The back end owns the key table and performs the halving search.
   stbs_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_op    (pop_op),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .rsp       (rsp_chan)
   );

endmodule

`default_nettype wire
